// ===== rtl/clipstk_pkg.sv =====
// Shared types, command codes and defaults for the clip rectangle stack.
`timescale 1ns / 1ps
package clipstk_pkg;

  localparam int STACK_DEPTH_DEF = 8;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [14:0] w;
    logic        [14:0] h;
  } rect_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

// ===== rtl/clip_rect_intersect_stack_top.sv =====
// Top level of the nested clip rectangle stack: cell chain, control, result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command word: push a
//   rectangle, pop the top entry or clear the stack; code 3 is ignored.
//   Output channel (out_valid / out_stall) returns one status word per
//   command: the top rectangle after the step (zeros when empty), the
//   depth, the clip enable flag and an overflow mark for a dropped push.
//   Result: the status word is registered and shows in the cycle after its command is taken.
//   Throughput: one command per cycle; the stack is a row of cells that all
//   shift in the same cycle, and the only logic ahead of the cells is the
//   intersect of the incoming rectangle with cell zero.
//   Stall: while a status word waits with out_stall high, in_stall is high
//   and no command is taken; the word and the stack hold.
//   Reset (rst, synchronous): depth and enable go to zero, the output word
//   is dropped and in_stall is held high, so no command is taken while rst
//   is high. Cell contents are not cleared; only cells below the depth
//   are ever shown.
//   A push onto a full stack is dropped, the stack is unchanged and the
//   status word carries overflow high.
`timescale 1ns / 1ps
module clip_rect_intersect_stack_top #(
  parameter int STACK_DEPTH = clipstk_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [1:0]  command,
  input  logic signed [15:0] rect_x,
  input  logic signed [15:0] rect_y,
  input  logic        [14:0] rect_w,
  input  logic        [14:0] rect_h,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] top_x,
  output logic signed [15:0] top_y,
  output logic        [14:0] top_w,
  output logic        [14:0] top_h,
  output logic        [3:0]  stack_depth,
  output logic               clip_enable,
  output logic               overflow
);
  import clipstk_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

  // Control registers
  logic [DW-1:0] depth_count, depth_count_next;
  logic          enable_flag, enable_flag_next;

  // Output word registers
  rect_t         out_rect;
  logic [DW-1:0] out_depth;
  logic          out_enable, out_overflow;

  logic    accept;
  logic    push_ok, push_full, pop_ok;
  shift_t  ctl;
  rect_t   new_rect, isect_rect, top_next;
  rect_t   cell_q [STACK_DEPTH];
  logic [DW+3:0] depth_wide;

  // Take a command whenever the result register is free or being emptied;
  // hold the input off throughout reset.
  assign in_stall = rst | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;

  assign new_rect = '{x: rect_x, y: rect_y, w: rect_w, h: rect_h};

  clipstk_isect u_isect (
    .a       (new_rect),
    .b       (cell_q[0]),
    .has_top (depth_count != '0),
    .r       (isect_rect)
  );

  // Decode the command; undefined code leaves the state alone.
  always_comb begin
    push_ok   = 1'b0;
    push_full = 1'b0;
    pop_ok    = 1'b0;
    depth_count_next = depth_count;
    enable_flag_next = enable_flag;
    if (accept) begin
      case (command)
        CMD_PUSH: begin
          if (depth_count == FULL) begin
            push_full = 1'b1;
          end else begin
            push_ok = 1'b1;
            depth_count_next = depth_count + 1'b1;
            enable_flag_next = 1'b1;
          end
        end
        CMD_POP: begin
          if (depth_count != '0) begin
            pop_ok = 1'b1;
            depth_count_next = depth_count - 1'b1;
          end
          // Switch clipping off once the stack is left empty.
          if (depth_count_next == '0) begin
            enable_flag_next = 1'b0;
          end
        end
        CMD_CLEAR: begin
          depth_count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign ctl.push = push_ok;
  assign ctl.pop  = pop_ok;

  // Cell chain: cell zero is the top of the stack.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    rect_t above, below;
    if (i == 0) begin : g_head
      assign above = isect_rect;
    end else begin : g_body
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign below = '0;
    end else begin : g_inner
      assign below = cell_q[i+1];
    end
    clipstk_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[i])
    );
  end

  // Top entry as it stands after this step; zeros when the stack empties.
  always_comb begin
    if (depth_count_next == '0) begin
      top_next = '0;
    end else if (push_ok) begin
      top_next = isect_rect;
    end else if (pop_ok) begin
      top_next = cell_q[1];
    end else begin
      top_next = cell_q[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_count <= '0;
      enable_flag <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      depth_count <= depth_count_next;
      enable_flag <= enable_flag_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result word on every accepted command, hold it otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_rect     <= top_next;
      out_depth    <= depth_count_next;
      out_enable   <= enable_flag_next;
      out_overflow <= push_full;
    end
  end

  assign depth_wide  = {4'b0000, out_depth};
  assign top_x       = out_rect.x;
  assign top_y       = out_rect.y;
  assign top_w       = out_rect.w;
  assign top_h       = out_rect.h;
  assign stack_depth = depth_wide[3:0];
  assign clip_enable = out_enable;
  assign overflow    = out_overflow;

  // Depth never runs past the cell count.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth_count <= FULL)
    else $error("stack depth beyond cell count");

  // A successful push always switches clipping on.
  a_push_enables: assert property (@(posedge clk) disable iff (rst)
    push_ok |=> enable_flag)
    else $error("push did not enable clipping");

  // A push onto a full stack is flagged and leaves the depth alone.
  a_full_flagged: assert property (@(posedge clk) disable iff (rst)
    push_full |=> out_valid && out_overflow && depth_count == FULL)
    else $error("dropped push not flagged");

  // A pop on a non-empty stack removes exactly one entry.
  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    pop_ok |=> depth_count == $past(depth_count) - 1'b1)
    else $error("pop did not remove one entry");

endmodule

// ===== rtl/clipstk_cell.sv =====
// One stack cell: holds a rectangle and shifts with its neighbours.
`timescale 1ns / 1ps
module clipstk_cell (
  input  logic                 clk,
  input  clipstk_pkg::shift_t  ctl,
  input  clipstk_pkg::rect_t   from_above,
  input  clipstk_pkg::rect_t   from_below,
  output clipstk_pkg::rect_t   q
);
  import clipstk_pkg::*;

  rect_t entry;

  // Take the upper neighbour on a push, the lower one on a pop, else hold.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entry <= from_above;
    end else if (ctl.pop) begin
      entry <= from_below;
    end
  end

  assign q = entry;

endmodule

// ===== rtl/clipstk_isect.sv =====
// Intersection of a pushed rectangle with the current top entry.
`timescale 1ns / 1ps
module clipstk_isect (
  input  clipstk_pkg::rect_t  a,
  input  clipstk_pkg::rect_t  b,
  input  logic                has_top,
  output clipstk_pkg::rect_t  r
);
  import clipstk_pkg::*;

  logic signed [16:0] ax2, bx2, ay2, by2, nx2, ny2;
  logic signed [15:0] nx, ny;
  logic signed [17:0] dw, dh;

  always_comb begin
    ax2 = $signed({a.x[15], a.x}) + $signed({2'b00, a.w});
    bx2 = $signed({b.x[15], b.x}) + $signed({2'b00, b.w});
    ay2 = $signed({a.y[15], a.y}) + $signed({2'b00, a.h});
    by2 = $signed({b.y[15], b.y}) + $signed({2'b00, b.h});
    nx  = ($signed(a.x) > $signed(b.x)) ? a.x : b.x;
    ny  = ($signed(a.y) > $signed(b.y)) ? a.y : b.y;
    nx2 = (ax2 < bx2) ? ax2 : bx2;
    ny2 = (ay2 < by2) ? ay2 : by2;
    dw  = $signed({nx2[16], nx2}) - $signed({nx[15], nx[15], nx});
    dh  = $signed({ny2[16], ny2}) - $signed({ny[15], ny[15], ny});
    if (has_top) begin
      r.x = nx;
      r.y = ny;
      r.w = dw[17] ? 15'd0 : dw[14:0];  // clamp empty overlap at zero
      r.h = dh[17] ? 15'd0 : dh[14:0];
    end else begin
      r = a;
    end
  end

endmodule

// ===== tb/clip_rect_intersect_stack_top_tb.sv =====
// Self-checking testbench for the nested clip rectangle stack.
`timescale 1ns / 1ps
module clip_rect_intersect_stack_top_tb;
  import clipstk_pkg::*;

  // Code 3 is not a command: the block must report its status and change nothing.
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 64;

  // One status word as the block reports it after a command.
  typedef struct packed {
    rect_t      top;
    logic [3:0] depth;
    logic       en;
    logic       ovf;
  } clip_status_t;

  // Tracks the stack as the block should hold it and queues the status words it owes.
  class clip_stack_predictor;
    rect_t        entries[STACK_DEPTH_DEF];
    int unsigned  depth;
    bit           enable;
    clip_status_t expected_status[$];
    int unsigned  errors, checked, pushes, dropped, pops, empty_pops, clears, ignored, deepest;

    function new();
      depth = 0;
      enable = 1'b0;
      errors = 0;
      checked = 0;
      pushes = 0;
      dropped = 0;
      pops = 0;
      empty_pops = 0;
      clears = 0;
      ignored = 0;
      deepest = 0;
    endfunction

    // Note one accepted command word and queue the status it must produce.
    function void take_command(logic [1:0] cmd, rect_t r);
      clip_status_t s;
      rect_t        p;
      int           ax, ay, aw, ah, px, py, pw, ph, nx, ny, nw, nh, edge_r, edge_b;
      s.ovf = 1'b0;
      case (cmd)
        CMD_PUSH: begin
          pushes++;
          if (depth >= STACK_DEPTH_DEF) begin
            s.ovf = 1'b1;
            dropped++;
          end else begin
            if (depth > 0) begin
              p  = entries[depth-1];
              ax = $signed(r.x);
              ay = $signed(r.y);
              aw = r.w;
              ah = r.h;
              px = $signed(p.x);
              py = $signed(p.y);
              pw = p.w;
              ph = p.h;
              nx = (ax > px) ? ax : px;
              ny = (ay > py) ? ay : py;
              edge_r = (ax + aw < px + pw) ? ax + aw : px + pw;
              edge_b = (ay + ah < py + ph) ? ay + ah : py + ph;
              nw = edge_r - nx;
              nh = edge_b - ny;
              if (nw < 0) nw = 0;
              if (nh < 0) nh = 0;
              r.x = nx[15:0];
              r.y = ny[15:0];
              r.w = nw[14:0];
              r.h = nh[14:0];
            end
            entries[depth] = r;
            depth++;
            enable = 1'b1;
            if (depth > deepest) deepest = depth;
          end
        end
        CMD_POP: begin
          pops++;
          if (depth > 0) depth--;
          else empty_pops++;
          if (depth == 0) enable = 1'b0;
        end
        CMD_CLEAR: begin
          clears++;
          depth = 0;
        end
        default: ignored++;
      endcase
      if (depth > 0) s.top = entries[depth-1];
      else s.top = '0;
      s.depth = 4'(depth);
      s.en = enable;
      expected_status = {expected_status, s};
    endfunction

    function void check_field(string name, logic signed [16:0] want, logic signed [16:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    // Compare one accepted status word against the oldest one owed.
    function void match_status(clip_status_t got);
      clip_status_t want;
      if (expected_status.size() == 0) begin
        errors++;
        $display("%0t: status word with no command outstanding, expected none, got %h",
                 $time, got);
        return;
      end
      want = expected_status.pop_front();
      checked++;
      check_field("top_x", $signed(want.top.x), $signed(got.top.x));
      check_field("top_y", $signed(want.top.y), $signed(got.top.y));
      check_field("top_w", want.top.w, got.top.w);
      check_field("top_h", want.top.h, got.top.h);
      check_field("stack_depth", want.depth, got.depth);
      check_field("clip_enable", want.en, got.en);
      check_field("overflow", want.ovf, got.ovf);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic        [1:0]  command;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic        [14:0] rect_w;
  logic        [14:0] rect_h;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] top_x;
  logic signed [15:0] top_y;
  logic        [14:0] top_w;
  logic        [14:0] top_h;
  logic        [3:0]  stack_depth;
  logic               clip_enable;
  logic               overflow;

  clip_stack_predictor board = new();

  // Percentages for the current phase: sender idle and receiver stall chance per cycle.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  // Raised by the stimulus to ask the receiver for one long hold-off.
  bit          hold_req = 1'b0;
  int unsigned cycle_count = 0;

  clip_rect_intersect_stack_top #(
    .STACK_DEPTH (STACK_DEPTH_DEF)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_w      (rect_w),
    .rect_h      (rect_h),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .top_x       (top_x),
    .top_y       (top_y),
    .top_w       (top_w),
    .top_h       (top_h),
    .stack_depth (stack_depth),
    .clip_enable (clip_enable),
    .overflow    (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: stall at the phase rate, or hold off for a long stretch when asked.
  // The hold is counted here so the sender keeps pushing words into a full block.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Check every status word taken at an edge; values are those before the edge.
  always @(posedge clk) begin
    clip_status_t got;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.top.x = top_x;
      got.top.y = top_y;
      got.top.w = top_w;
      got.top.h = top_h;
      got.depth = stack_depth;
      got.en    = clip_enable;
      got.ovf   = overflow;
      board.match_status(got);
    end
  end

  // Watchdog: a run that hangs on a handshake ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d status words still owed",
             $time, cycle_count, board.expected_status.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic rect_t mk_rect(int x, int y, int w, int h);
    rect_t r;
    r.x = x[15:0];
    r.y = y[15:0];
    r.w = w[14:0];
    r.h = h[14:0];
    return r;
  endfunction

  // Mostly rectangles around the origin so nested pushes overlap in interesting ways;
  // the rest span the whole field range or sit on its extremes.
  function automatic rect_t pick_rect();
    int    sel;
    rect_t r;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      r = mk_rect($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                  $urandom_range(0, 500), $urandom_range(0, 500));
    end else if (sel < 9) begin
      r.x = 16'($urandom);
      r.y = 16'($urandom);
      r.w = 15'($urandom);
      r.h = 15'($urandom);
    end else begin
      r.x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      r.y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      r.w = $urandom_range(0, 1) ? 15'h7fff : 15'h0000;
      r.h = $urandom_range(0, 1) ? 15'h7fff : 15'h0000;
    end
    return r;
  endfunction

  // Pushes outweigh pops so the stack wanders up to full; clears pull it back down.
  function automatic logic [1:0] pick_command();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return CMD_PUSH;
    if (p < 85) return CMD_POP;
    if (p < 94) return CMD_CLEAR;
    return CMD_IGNORED;
  endfunction

  // Offer one command word, idling first at the phase rate; hold it until taken.
  // in_valid stays high on return so back-to-back words need no gap.
  task automatic offer_command(logic [1:0] cmd, rect_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    rect_x   <= r.x;
    rect_y   <= r.y;
    rect_w   <= r.w;
    rect_h   <= r.h;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.take_command(cmd, r);
  endtask

  // Drop valid and wait until every owed status word has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.expected_status.size() != 0);
  endtask

  // Random commands until n of them are real operations; ignored codes ride along.
  task automatic run_random(int n);
    int         done;
    logic [1:0] cmd;
    done = 0;
    while (done < n) begin
      cmd = pick_command();
      offer_command(cmd, pick_rect());
      if (cmd != CMD_IGNORED) done++;
    end
  endtask

  task automatic run_directed();
    // Pop and an ignored code on the empty stack.
    offer_command(CMD_POP, mk_rect(0, 0, 0, 0));
    offer_command(CMD_IGNORED, mk_rect(-1, -1, 32767, 32767));
    // Widest rectangle, then one wholly beyond its far corner: clamps to zero size.
    offer_command(CMD_PUSH, mk_rect(-32768, -32768, 32767, 32767));
    offer_command(CMD_PUSH, mk_rect(32767, 32767, 32767, 32767));
    offer_command(CMD_PUSH, mk_rect(0, 0, 100, 100));
    offer_command(CMD_POP, mk_rect(0, 0, 0, 0));
    offer_command(CMD_POP, mk_rect(0, 0, 0, 0));
    offer_command(CMD_PUSH, mk_rect(-10, -20, 0, 0));
    // Clear keeps clipping on; a pop on the cleared stack turns it off.
    offer_command(CMD_CLEAR, mk_rect(0, 0, 0, 0));
    offer_command(CMD_CLEAR, mk_rect(0, 0, 0, 0));
    offer_command(CMD_POP, mk_rect(0, 0, 0, 0));
    // Fill the stack with shrinking nested boxes; the ninth push is dropped.
    for (int i = 0; i < STACK_DEPTH_DEF + 1; i++)
      offer_command(CMD_PUSH, mk_rect(-1000 + i * 50, -800 + i * 40, 2000 - i * 30,
                                      1600 - i * 20));
    offer_command(CMD_PUSH, mk_rect(-32768, 32767, 32767, 0));
    offer_command(CMD_IGNORED, mk_rect(0, 0, 0, 0));
    offer_command(CMD_POP, mk_rect(0, 0, 0, 0));
    offer_command(CMD_PUSH, mk_rect(32767, -32768, 0, 32767));
  endtask

  initial begin
    int unsigned phase_idle[4];
    int unsigned phase_stall[4];
    phase_idle  = '{0, 61, 0, 19};
    phase_stall = '{0, 0, 61, 19};
    rst      <= 1'b1;
    in_valid <= 1'b0;
    command  <= CMD_PUSH;
    rect_x   <= '0;
    rect_y   <= '0;
    rect_w   <= '0;
    rect_h   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      if (ph == 0) begin
        // Hold the receiver off while the sender keeps offering: block fills and stalls.
        hold_req = 1'b1;
        run_random(150);
      end else if (ph == 2) begin
        // Pause the sender halfway until the stack's status words are all home.
        run_random(75);
        drain_results();
        run_random(75);
      end else begin
        run_random(150);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);

    $display("Covered %0d pushes (%0d dropped when full), %0d pops (%0d on empty), %0d clears,",
             board.pushes, board.dropped, board.pops, board.empty_pops, board.clears);
    $display("%0d ignored codes; deepest nesting %0d, %0d status words checked, %0d mismatches.",
             board.ignored, board.deepest, board.checked, board.errors);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== clip_rect_intersect_stack_top.f =====
rtl/clipstk_pkg.sv
rtl/clipstk_cell.sv
rtl/clipstk_isect.sv
rtl/clip_rect_intersect_stack_top.sv
tb/clip_rect_intersect_stack_top_tb.sv
